FILE: hw/rtl/adcavg_pkg.sv
`timescale 1ns / 1ps

package adcavg_pkg;

    // Input and result field widths.
    localparam int SAMPLE_W = 12;
    localparam int MV_W     = 12;
    localparam int SUM_W    = 20;
    localparam int COUNT_W  = 8;
    localparam int SETTLE_W = 4;
    localparam int DWELL_W  = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPA    = 2'd0,
        CFG_SETTLE = 2'd1,
        CFG_DWELL  = 2'd2
    } t_cfg_idx;

    localparam logic [COUNT_W-1:0]  SPA_RST    = 8'd100;
    localparam logic [SETTLE_W-1:0] SETTLE_RST = 4'd3;
    localparam logic [DWELL_W-1:0]  DWELL_RST  = 8'd100;

    typedef struct packed {
        logic [COUNT_W-1:0]  spa;
        logic [SETTLE_W-1:0] settle;
        logic [DWELL_W-1:0]  dwell_limit;
    } t_cfg;

    // Scaling 1000/1240 reduces to 25/31 without changing the floor.
    localparam int MV_NUM = 25;
    localparam int MV_DEN = 31;
    localparam logic [MV_W-1:0] MV_MAX = 12'd3302;

    // Division by 31 as a reciprocal multiply. The scaled sum stays below 2^25
    // and the rounding error of the reciprocal times that bound stays below
    // 2^30, so the shifted product is the exact floor.
    localparam int RECIP_W  = 26;
    localparam int MV_SHIFT = 30;
    localparam logic [RECIP_W-1:0] MV_RECIP =
        RECIP_W'(((64'd1 << MV_SHIFT) + MV_DEN - 1) / MV_DEN);

    // Restoring divider for the division by the sample count.
    localparam int NUM_W      = 25;   // holds sum * 25
    localparam int Q1_W       = 20;   // quotient of the scaling step
    localparam int REM_W      = 8;
    localparam int ITER_W     = 5;
    localparam int DIV2_STEPS = Q1_W;

    // Microcode.
    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_GATE,
        OP_ACC,
        OP_MUL,
        OP_RECIP,
        OP_DIV,
        OP_LOAD2,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT,
        C_NO_REQ,
        C_DISCARD,
        C_NOT_FULL,
        C_DIV_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Status flags from the datapath that the jump conditions test.
    typedef struct packed {
        logic no_req;
        logic discard;
        logic not_full;
        logic div_more;
        logic out_busy;
    } t_flags;

endpackage

FILE: hw/rtl/adc_channel_averager.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+-----------------------------------
// input    | in        | i_in_valid / o_in_stall  | i_sample
// output   | out       | o_out_valid / i_out_stall| o_channel, o_millivolts,
//          |           |                          | o_next_channel
// config   | in        | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
// A discarded settling request runs the wait and gate steps, and a summed request without
// a result adds the accumulate step. For a request that completes an average, the 25/31
// scaling is one multiply step and one reciprocal step, and the restoring divider then
// retires one quotient bit per cycle, 20 steps for the division by the count.
// Reset is synchronous and active low; it restores the register defaults and
// restarts settling on channel 0.
// A new request is accepted while a finished result waits; only the final step of
// the next result holds while the output is stalled.

module adc_channel_averager #(
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [adcavg_pkg::SAMPLE_W-1:0]       i_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_channel,
    output logic [adcavg_pkg::MV_W-1:0]           o_millivolts,
    output logic                                  o_next_channel,
    input  logic                                  i_cfg_we,
    input  logic [adcavg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [adcavg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import adcavg_pkg::*;

    // Configuration registers. Writes to an index past the list are ignored.
    t_cfg   r_cfg;
    t_op    w_op;
    t_flags w_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spa         <= SPA_RST;
            r_cfg.settle      <= SETTLE_RST;
            r_cfg.dwell_limit <= DWELL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPA:    r_cfg.spa         <= i_cfg_data[COUNT_W-1:0];
                CFG_SETTLE: r_cfg.settle      <= i_cfg_data[SETTLE_W-1:0];
                CFG_DWELL:  r_cfg.dwell_limit <= i_cfg_data[DWELL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The sequencer steps through the microprogram; the datapath carries out
    // one operation per step and reports the flags that the jumps test.
    adcavg_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_op    (w_op)
    );

    adcavg_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (w_op),
        .i_cfg          (r_cfg),
        .o_flags        (w_flags),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_channel      (o_channel),
        .o_millivolts   (o_millivolts),
        .o_next_channel (o_next_channel)
    );

    // A result only appears after the emit step of the microprogram.
    a_rise_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_op == OP_EMIT))
        else $error("result appeared outside the emit step");

    // The averaged value never exceeds full scale.
    a_mv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_millivolts <= MV_MAX))
        else $error("millivolt result above full scale");

    // Channel 1 always hands back to channel 0.
    a_chan1_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_channel) |-> !o_next_channel)
        else $error("channel 1 did not return to channel 0");

    // No request is taken while the divider is busy.
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == OP_DIV) |-> o_in_stall)
        else $error("input open during division");

endmodule

FILE: hw/rtl/adcavg_sequencer.sv
`timescale 1ns / 1ps

module adcavg_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  adcavg_pkg::t_flags i_flags,
    output adcavg_pkg::t_op    o_op
);
    import adcavg_pkg::*;

    localparam t_pc PC_WAIT = 3'd0;
    localparam t_pc PC_DIV2 = 3'd6;
    localparam t_pc PC_EMIT = 3'd7;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_word;
    logic   w_jump;

    // Program. The last step falls through to step zero.
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            3'd0:    w = '{op: OP_WAIT,  cond: C_NO_REQ,   target: PC_WAIT};
            3'd1:    w = '{op: OP_GATE,  cond: C_DISCARD,  target: PC_WAIT};
            3'd2:    w = '{op: OP_ACC,   cond: C_NOT_FULL, target: PC_WAIT};
            3'd3:    w = '{op: OP_MUL,   cond: C_NEXT,     target: PC_WAIT};
            3'd4:    w = '{op: OP_RECIP, cond: C_NEXT,     target: PC_WAIT};
            3'd5:    w = '{op: OP_LOAD2, cond: C_NEXT,     target: PC_WAIT};
            3'd6:    w = '{op: OP_DIV,   cond: C_DIV_MORE, target: PC_DIV2};
            3'd7:    w = '{op: OP_EMIT,  cond: C_OUT_BUSY, target: PC_EMIT};
            default: w = '{op: OP_WAIT,  cond: C_NO_REQ,   target: PC_WAIT};
        endcase
        return w;
    endfunction

    assign w_word = ucode(r_pc);
    assign o_op   = w_word.op;

    always_comb begin
        unique case (w_word.cond)
            C_NEXT:     w_jump = 1'b0;
            C_NO_REQ:   w_jump = i_flags.no_req;
            C_DISCARD:  w_jump = i_flags.discard;
            C_NOT_FULL: w_jump = i_flags.not_full;
            C_DIV_MORE: w_jump = i_flags.div_more;
            C_OUT_BUSY: w_jump = i_flags.out_busy;
            default:    w_jump = 1'b0;
        endcase
        n_pc = w_jump ? w_word.target : r_pc + t_pc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

FILE: hw/rtl/adcavg_datapath.sv
`timescale 1ns / 1ps

module adcavg_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  adcavg_pkg::t_op                     i_op,
    input  adcavg_pkg::t_cfg                    i_cfg,
    output adcavg_pkg::t_flags                  o_flags,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [adcavg_pkg::SAMPLE_W-1:0]     i_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_channel,
    output logic [adcavg_pkg::MV_W-1:0]         o_millivolts,
    output logic                                o_next_channel
);
    import adcavg_pkg::*;

    // Control state.
    logic [SETTLE_W-1:0] r_settle;
    logic                r_summing;
    logic [SUM_W-1:0]    r_sum;
    logic [COUNT_W-1:0]  r_count;
    logic                r_chan;
    logic [DWELL_W-1:0]  r_dwell;
    logic                r_out_valid;

    // Payload.
    logic [SAMPLE_W-1:0] r_sample;
    logic [NUM_W-1:0]    r_num;
    logic [REM_W-1:0]    r_rem;
    logic [COUNT_W-1:0]  r_den;
    logic [ITER_W-1:0]   r_iter;
    logic                r_out_chan;
    logic [MV_W-1:0]     r_out_mv;
    logic                r_out_next;

    logic [COUNT_W-1:0]  n_count;
    logic [NUM_W+RECIP_W-1:0] n_prod;
    logic [REM_W:0]      n_rem_sh;
    logic                n_qbit;
    logic [REM_W-1:0]    n_rem;
    logic [DWELL_W:0]    n_dwell;
    logic                n_switch;
    logic                n_next;
    logic                w_discard;
    logic                w_out_busy;
    logic                w_emit;

    always_comb begin
        w_discard  = !r_summing && (r_settle < i_cfg.settle);
        n_count    = r_count + COUNT_W'(1);
        if (n_count == '0) begin
            n_count = COUNT_W'(1);
        end
        w_out_busy = r_out_valid && i_out_stall;
        w_emit     = (i_op == OP_EMIT) && !w_out_busy;

        // Scaled sum times the reciprocal of 31.
        n_prod = (NUM_W + RECIP_W)'(r_num) * (NUM_W + RECIP_W)'(MV_RECIP);

        // One restoring division step.
        n_rem_sh = {r_rem, r_num[NUM_W-1]};
        n_qbit   = n_rem_sh >= {1'b0, r_den};
        n_rem    = n_qbit ? REM_W'(n_rem_sh - {1'b0, r_den}) : REM_W'(n_rem_sh);

        // Channel sequencing; the dwell count is compared one bit wider.
        n_dwell  = {1'b0, r_dwell} + (DWELL_W + 1)'(1);
        n_switch = n_dwell > {1'b0, i_cfg.dwell_limit};
        n_next   = r_chan ? 1'b0 : n_switch;
    end

    assign o_flags.no_req   = !i_in_valid;
    assign o_flags.discard  = w_discard;
    assign o_flags.not_full = n_count < i_cfg.spa;
    assign o_flags.div_more = r_iter != '0;
    assign o_flags.out_busy = w_out_busy;

    assign o_in_stall     = i_op != OP_WAIT;
    assign o_out_valid    = r_out_valid;
    assign o_channel      = r_out_chan;
    assign o_millivolts   = r_out_mv;
    assign o_next_channel = r_out_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle    <= '0;
            r_summing   <= 1'b0;
            r_sum       <= '0;
            r_count     <= '0;
            r_chan      <= 1'b0;
            r_dwell     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (i_op)
                OP_WAIT: begin
                    if (i_in_valid) begin
                        r_sample <= i_sample;
                    end
                end
                OP_GATE: begin
                    if (w_discard) begin
                        r_settle <= r_settle + SETTLE_W'(1);
                    end else begin
                        r_summing <= 1'b1;
                        r_settle  <= '0;
                    end
                end
                OP_ACC: begin
                    r_sum   <= r_sum + SUM_W'(r_sample);
                    r_count <= n_count;
                end
                OP_MUL: begin
                    r_num <= NUM_W'(r_sum * MV_NUM);
                    r_sum <= '0;
                end
                OP_RECIP: begin
                    r_num <= NUM_W'(n_prod[MV_SHIFT +: Q1_W]);
                end
                OP_DIV: begin
                    r_num <= {r_num[NUM_W-2:0], n_qbit};
                    r_rem <= n_rem;
                    if (r_iter != '0) begin
                        r_iter <= r_iter - ITER_W'(1);
                    end
                end
                OP_LOAD2: begin
                    r_num   <= {r_num[Q1_W-1:0], {(NUM_W - Q1_W){1'b0}}};
                    r_rem   <= '0;
                    r_den   <= r_count;
                    r_iter  <= ITER_W'(DIV2_STEPS - 1);
                    r_count <= '0;
                end
                OP_EMIT: begin
                    if (w_emit) begin
                        r_out_chan <= r_chan;
                        r_out_mv   <= r_num[MV_W-1:0];
                        r_out_next <= n_next;
                        if (!r_chan) begin
                            r_dwell <= n_switch ? '0 : n_dwell[DWELL_W-1:0];
                        end
                        if (n_next != r_chan) begin
                            r_summing <= 1'b0;
                            r_settle  <= '0;
                            r_chan    <= n_next;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: tb/sv/adc_channel_averager_tb.sv
`timescale 1ns / 1ps

module adc_channel_averager_tb;

    import adcavg_pkg::*;

    // A result request runs through every microprogram step. Requests ending in no
    // result stop at the gate or accumulate step, but one may still be in flight
    // when the last result shows up, so register writes wait this long first.
    localparam int DRAIN_CYCLES   = 64;
    // Length of the single long receiver hold-off used to back up the block.
    localparam int HOLD_CYCLES    = 400;
    // Cycles without any accepted request, result or register write before we
    // give up. The longest legal quiet stretch is the hold-off plus one average.
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic            ch;
        logic [MV_W-1:0] mv;
        logic            nxt;
    } t_avg_result;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_SAMPLE,
        ROW_CHECKED
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_cfg_idx              reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [SAMPLE_W-1:0]   smp;
        t_avg_result           res;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [SAMPLE_W-1:0]   i_sample;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_channel;
    logic [MV_W-1:0]       o_millivolts;
    logic                  o_next_channel;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    adc_channel_averager dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_channel      (o_channel),
        .o_millivolts   (o_millivolts),
        .o_next_channel (o_next_channel),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the configuration and of the averaging state. It is
    // updated when a request or a register write is accepted, so it always
    // reflects what the block should hold at that point.
    t_cfg                avg_cfg;
    logic [SETTLE_W-1:0] settle_cnt;
    logic                sum_en;
    logic [SUM_W-1:0]    acc_sum;
    logic [COUNT_W-1:0]  acc_cnt;
    logic                cur_ch;
    logic [DWELL_W-1:0]  dwell_cnt;

    // Averages still owed by the block, oldest first.
    t_avg_result mv_expect_q[$];
    t_stim_row   stim_rows[$];

    int err_cnt       = 0;
    int quiet_cycles  = 0;
    int snd_idle_pct  = 38;
    int rcv_idle_pct  = 57;
    bit hold_off_req  = 1'b0;

    // Advance the shadow state by one accepted sample. A result comes out only
    // when the configured number of samples has been summed.
    function automatic void average_step(input logic [SAMPLE_W-1:0] s, output bit has,
                                         output t_avg_result r);
        int unsigned       scaled;
        logic [DWELL_W:0]  dwell_next;
        has = 1'b0;
        r   = '0;
        // Settling samples after reset or a channel switch are dropped. Once the
        // count is reached the same sample already goes into the sum.
        if (!sum_en) begin
            if (settle_cnt < avg_cfg.settle) begin
                settle_cnt = settle_cnt + 1'b1;
                return;
            end
            sum_en     = 1'b1;
            settle_cnt = '0;
        end
        acc_sum = acc_sum + SUM_W'(s);
        acc_cnt = acc_cnt + 1'b1;
        if (acc_cnt == '0) begin
            acc_cnt = COUNT_W'(1);
        end
        // A count of zero behaves like one, and a count lowered below the number
        // already summed fires on this sample with the true divisor.
        if (acc_cnt < avg_cfg.spa) begin
            return;
        end
        scaled  = (int'(acc_sum) * 1000) / 1240;
        r.mv    = MV_W'(scaled / int'(acc_cnt));
        r.ch    = cur_ch;
        acc_sum = '0;
        acc_cnt = '0;
        // Channel 0 dwells until its average count passes the limit; the
        // compare is one bit wider so a limit of 255 still switches.
        r.nxt = 1'b0;
        if (cur_ch == 1'b0) begin
            dwell_next = {1'b0, dwell_cnt} + 1'b1;
            if (dwell_next > {1'b0, avg_cfg.dwell_limit}) begin
                r.nxt     = 1'b1;
                dwell_cnt = '0;
            end else begin
                dwell_cnt = dwell_next[DWELL_W-1:0];
            end
        end
        if (r.nxt != cur_ch) begin
            sum_en     = 1'b0;
            settle_cnt = '0;
            cur_ch     = r.nxt;
        end
        has = 1'b1;
    endfunction

    function automatic void add_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row          = '0;
        row.kind     = ROW_WRITE;
        row.reg_idx  = idx;
        row.reg_data = data;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_sample(input logic [SAMPLE_W-1:0] s);
        t_stim_row row;
        row      = '0;
        row.kind = ROW_SAMPLE;
        row.smp  = s;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_checked(input logic [SAMPLE_W-1:0] s, input logic ch,
                                        input logic [MV_W-1:0] mv, input logic nxt);
        t_stim_row row;
        row        = '0;
        row.kind   = ROW_CHECKED;
        row.smp    = s;
        row.res.ch = ch;
        row.res.mv = mv;
        row.res.nxt = nxt;
        stim_rows.push_back(row);
    endfunction

    // Offer one sample request and return once the block has taken it. The
    // sender idles at random before raising valid, then holds the payload.
    task automatic accept_sample(input logic [SAMPLE_W-1:0] s);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until the block has delivered every average owed.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (mv_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Registers only change while the block is idle: drain, let any pending
    // settling or summing request finish, then write for one cycle.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_SPA:    avg_cfg.spa         = data;
            CFG_SETTLE: avg_cfg.settle      = data[SETTLE_W-1:0];
            CFG_DWELL:  avg_cfg.dwell_limit = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One random phase at a fixed setting. Samples lean toward the rails so
    // full-scale sums show up often. hold_at starts the long receiver hold-off
    // at that request, and pause_at lets every owed average out first.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] spa,
                             input logic [CFG_DATA_W-1:0] settle,
                             input logic [CFG_DATA_W-1:0] dwell, input int n,
                             input int hold_at, input int pause_at);
        logic [SAMPLE_W-1:0] s;
        bit                  has;
        t_avg_result         res;
        write_reg(CFG_SPA, spa);
        write_reg(CFG_SETTLE, settle);
        write_reg(CFG_DWELL, dwell);
        for (int k = 0; k < n; k++) begin
            if (k == hold_at) begin
                hold_off_req = 1'b1;
            end
            if (k == pause_at) begin
                drain_results();
            end
            case ($urandom_range(0, 7))
                0:       s = '0;
                1:       s = '1;
                default: s = SAMPLE_W'($urandom_range(0, 4095));
            endcase
            accept_sample(s);
            average_step(s, has, res);
            if (has) begin
                mv_expect_q.push_back(res);
            end
        end
    endtask

    task automatic report(input string field, input int exp_val, input int act_val);
        $display("%0t: mismatch on %s, expected %0d, got %0d", $time, field, exp_val, act_val);
        err_cnt++;
    endtask

    // Result checker: every accepted average is matched against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        t_avg_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (mv_expect_q.size() == 0) begin
                $display("%0t: unexpected average, channel %0d millivolts %0d next %0d",
                         $time, o_channel, o_millivolts, o_next_channel);
                err_cnt++;
            end else begin
                e = mv_expect_q.pop_front();
                if (o_channel !== e.ch) begin
                    report("channel", e.ch, o_channel);
                end
                if (o_millivolts !== e.mv) begin
                    report("millivolts", e.mv, o_millivolts);
                end
                if (o_next_channel !== e.nxt) begin
                    report("next_channel", e.nxt, o_next_channel);
                end
            end
        end
    end

    // Watchdog: any accepted request, result or register write counts as
    // progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random stalls at the current rate, plus one long hold-off on
    // request so the block fills up and has to stall its input.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                repeat (HOLD_CYCLES) begin
                    i_out_stall <= 1'b1;
                    @(negedge i_clk);
                end
                hold_off_req = 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
            end
        end
    end

    initial begin
        bit          has;
        t_avg_result res;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_sample   = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_SPA;
        i_cfg_data = '0;

        avg_cfg.spa         = SPA_RST;
        avg_cfg.settle      = SETTLE_RST;
        avg_cfg.dwell_limit = DWELL_RST;
        settle_cnt = '0;
        sum_en     = 1'b0;
        acc_sum    = '0;
        acc_cnt    = '0;
        cur_ch     = 1'b0;
        dwell_cnt  = '0;

        // Directed part. Settling keeps its reset value of three at first, so
        // each channel drops three samples before its single-sample average.
        // A dwell limit of zero makes every channel 0 average switch over.
        add_write(CFG_SPA, 8'd1);
        add_write(CFG_DWELL, 8'd0);
        add_sample(12'hFFF);
        add_sample(12'hFFF);
        add_sample(12'hFFF);
        add_checked(12'h000, 1'b0, 12'd0, 1'b1);
        add_sample(12'h000);
        add_sample(12'h000);
        add_sample(12'h000);
        add_checked(12'hFFF, 1'b1, 12'd3302, 1'b0);
        add_sample(12'hAAA);
        add_sample(12'h555);
        add_sample(12'h000);
        add_checked(12'hFFF, 1'b0, 12'd3302, 1'b1);
        // No settling at all, pairs of samples, channel 0 holds for two averages.
        add_write(CFG_SETTLE, 8'd0);
        add_write(CFG_SPA, 8'd2);
        add_write(CFG_DWELL, 8'd1);
        add_sample(12'h001);
        add_sample(12'h002);
        add_sample(12'hFFF);
        add_sample(12'hFFF);
        add_sample(12'h800);
        add_sample(12'h7FF);
        // A count of zero acts like one, with one settling sample per channel.
        add_write(CFG_SPA, 8'd0);
        add_write(CFG_SETTLE, 8'd1);
        add_sample(12'h123);
        add_sample(12'h456);
        add_sample(12'h789);
        add_sample(12'hABC);
        // Count lowered in the middle of an average: the next sample closes it
        // and the divisor is the three samples actually summed.
        add_write(CFG_SPA, 8'd3);
        add_sample(12'h100);
        add_sample(12'h200);
        add_write(CFG_SPA, 8'd1);
        add_sample(12'h300);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            if (stim_rows[k].kind == ROW_WRITE) begin
                write_reg(stim_rows[k].reg_idx, stim_rows[k].reg_data);
            end else begin
                accept_sample(stim_rows[k].smp);
                average_step(stim_rows[k].smp, has, res);
                if (stim_rows[k].kind == ROW_CHECKED) begin
                    res = stim_rows[k].res;
                end
                if (has) begin
                    mv_expect_q.push_back(res);
                end
            end
        end

        // Random part. The long settling phase with spa of one and the widest
        // dwell limit runs long enough to see the switch after 256 averages.
        run_phase(8'd4, 8'd2, 8'd3, 150, -1, -1);
        run_phase(8'd1, 8'd15, 8'd255, 320, -1, 100);
        run_phase(8'd255, 8'd0, 8'd0, 280, -1, -1);

        snd_idle_pct = 57;
        rcv_idle_pct = 38;
        run_phase(8'd0, 8'd1, 8'd2, 150, 20, -1);
        // Upper bits of the settling write are not part of the register.
        run_phase(8'd7, 8'hA5, 8'd10, 150, -1, -1);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_phase(8'd2, 8'd0, 8'd1, 120, -1, -1);
        run_phase(8'd13, 8'd3, 8'd5, 60, -1, -1);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
